// ----- sv/itt_pkg.sv -----
`default_nettype none

package itt_pkg;

  // Table geometry
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  // Fixed field widths
  localparam int unsigned IdW   = 31;
  localparam int unsigned TypeW = 31;
  localparam int unsigned ActW  = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned PosW  = 6;

  localparam logic [IdW-1:0] InitialId = IdW'(1);
  localparam logic [IdW-1:0] MaxId     = {IdW{1'b1}};

  typedef enum logic [ActW-1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // One stored pair
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TypeW-1:0] mtype;
  } entry_t;

endpackage

`default_nettype wire

// ----- sv/itt_mem.sv -----
`default_nettype none

module itt_mem (
  input  wire                              clk_i,
  input  wire                              wr_en_i,
  input  wire  [itt_pkg::IdxW-1:0]         wr_addr_i,
  input  wire  itt_pkg::entry_t            wr_data_i,
  input  wire  [itt_pkg::IdxW-1:0]         rd_addr_i,
  output itt_pkg::entry_t                  rd_data_o
);

  itt_pkg::entry_t mem_q [itt_pkg::Capacity];
  itt_pkg::entry_t rd_data_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/id_to_type_table_unit.sv -----
`default_nettype none

// Channel   | Handshake         | Payload
// ----------+-------------------+---------------------------------------------
// command   | start / busy      | action_i, msg_type_i, key_id_i
// result    | done_o (strobe)   | status_o, new_id_o, found_type_o,
//           |                   | found_position_o
//
// Add strobes its result in the cycle after the accepting edge; busy stays low.
// Lookup scans the table through the single memory read port, one entry per
// busy cycle, then strobes the result. Remove scans to the match at position
// p, then moves each later entry down one place through the same port, then
// strobes the result.
// Reset sets the counter to 1 and the fill count to 0; the memory is not cleared.
// The result strobe lasts one cycle and cannot be held off.
module id_to_type_table_unit (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [itt_pkg::ActW-1:0]       action_i,
  input  wire  [itt_pkg::TypeW-1:0]      msg_type_i,
  input  wire  [itt_pkg::IdW-1:0]        key_id_i,
  output logic                           done_o,
  output logic [itt_pkg::StW-1:0]        status_o,
  output logic [itt_pkg::IdW-1:0]        new_id_o,
  output logic [itt_pkg::TypeW-1:0]      found_type_o,
  output logic [itt_pkg::PosW-1:0]       found_position_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [itt_pkg::IdW-1:0]     counter_q, counter_d;
  logic [itt_pkg::CntW-1:0]    count_q, count_d;
  logic [itt_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [itt_pkg::CntW-1:0]    idx_next;
  logic [itt_pkg::IdW-1:0]     key_q, key_d;
  logic                        remove_q, remove_d;

  logic                        done_q, done_d;
  logic [itt_pkg::StW-1:0]     status_q, status_d;
  logic [itt_pkg::IdW-1:0]     new_id_q, new_id_d;
  logic [itt_pkg::TypeW-1:0]   ftype_q, ftype_d;
  logic [itt_pkg::PosW-1:0]    fpos_q, fpos_d;

  logic                        wr_en;
  logic [itt_pkg::IdxW-1:0]    wr_addr;
  itt_pkg::entry_t             wr_data;
  logic [itt_pkg::IdxW-1:0]    rd_addr;
  itt_pkg::entry_t             rd_data;
  logic                        accept;

  itt_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign idx_next = itt_pkg::CntW'(idx_q) + itt_pkg::CntW'(1);

  // Prefetch entry 0 when idle, the following entry otherwise
  assign rd_addr = (state_q == S_IDLE) ? '0 : idx_next[itt_pkg::IdxW-1:0];

  // Sequencer: add, scan, compact
  always_comb begin
    state_d   = state_q;
    counter_d = counter_q;
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    remove_d  = remove_q;
    done_d    = 1'b0;
    status_d  = status_q;
    new_id_d  = new_id_q;
    ftype_d   = ftype_q;
    fpos_d    = fpos_q;
    wr_en     = 1'b0;
    wr_addr   = count_q[itt_pkg::IdxW-1:0];
    wr_data   = '{id: counter_q, mtype: msg_type_i};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d    = key_id_i;
          idx_d    = '0;
          status_d = itt_pkg::ST_OK;
          new_id_d = '0;
          ftype_d  = '0;
          fpos_d   = '0;
          case (itt_pkg::action_e'(action_i))
            itt_pkg::ACT_ADD: begin
              done_d = 1'b1;
              if (count_q >= itt_pkg::CntW'(itt_pkg::Capacity)) begin
                status_d = itt_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                new_id_d  = counter_q;
                counter_d = (counter_q == itt_pkg::MaxId) ? itt_pkg::InitialId
                                                          : counter_q + 1'b1;
                count_d   = count_q + 1'b1;
              end
            end
            itt_pkg::ACT_LOOKUP, itt_pkg::ACT_REMOVE: begin
              remove_d = (action_i == itt_pkg::ACT_REMOVE);
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = itt_pkg::ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              // Drop the unused code: no beat and no table change, but the result fields are cleared
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_data.id == key_q) begin
          if (!remove_q) begin
            done_d  = 1'b1;
            ftype_d = rd_data.mtype;
            state_d = S_IDLE;
          end else begin
            fpos_d = itt_pkg::PosW'(idx_q);
            if (idx_next == count_q) begin
              done_d  = 1'b1;
              count_d = count_q - 1'b1;
              state_d = S_IDLE;
            end else begin
              idx_d   = idx_next[itt_pkg::IdxW-1:0];
              state_d = S_SHIFT;
            end
          end
        end else if (idx_next == count_q) begin
          done_d   = 1'b1;
          status_d = itt_pkg::ST_NOT_FOUND;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_next[itt_pkg::IdxW-1:0];
        end
      end

      S_SHIFT: begin
        // Move the entry at idx down one place
        wr_en   = 1'b1;
        wr_addr = idx_q - 1'b1;
        wr_data = rd_data;
        if (idx_next == count_q) begin
          done_d  = 1'b1;
          count_d = count_q - 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_next[itt_pkg::IdxW-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      counter_q <= itt_pkg::InitialId;
      count_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      counter_q <= counter_d;
      count_q   <= count_d;
      done_q    <= done_d;
    end
  end

  // Hold payload and result registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    remove_q <= remove_d;
    status_q <= status_d;
    new_id_q <= new_id_d;
    ftype_q  <= ftype_d;
    fpos_q   <= fpos_d;
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign new_id_o         = new_id_q;
  assign found_type_o     = ftype_q;
  assign found_position_o = fpos_q;

endmodule

`default_nettype wire

// ----- tb/tb_id_to_type_table_unit.sv -----
`default_nettype none

module tb_id_to_type_table_unit;

  localparam logic [itt_pkg::ActW-1:0] ActUnused = 2'd3;
  localparam int unsigned NumItems = 850;
  localparam int unsigned TailCycles = 100;
  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic [itt_pkg::ActW-1:0]  action;
    logic [itt_pkg::TypeW-1:0] mtype;
    logic [itt_pkg::IdW-1:0]   key;
    int unsigned               gap;
  } cmd_t;

  typedef struct {
    itt_pkg::status_e          status;
    logic [itt_pkg::IdW-1:0]   new_id;
    logic [itt_pkg::TypeW-1:0] ftype;
    logic [itt_pkg::PosW-1:0]  pos;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start = 1'b0;
  logic busy;
  logic [itt_pkg::ActW-1:0] action_i = '0;
  logic [itt_pkg::TypeW-1:0] msg_type_i = '0;
  logic [itt_pkg::IdW-1:0] key_id_i = '0;
  logic done_o;
  logic [itt_pkg::StW-1:0] status_o;
  logic [itt_pkg::IdW-1:0] new_id_o;
  logic [itt_pkg::TypeW-1:0] found_type_o;
  logic [itt_pkg::PosW-1:0] found_position_o;

  // Shadow of the table, updated as each command beat is accepted
  logic [itt_pkg::IdW-1:0] id_next;
  int unsigned fill;
  itt_pkg::entry_t slots [itt_pkg::Capacity];

  cmd_t pending_cmds[$];
  reply_t expected_replies[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Driver staging
  cmd_t cur;
  cmd_t nxt;
  logic staged = 1'b0;
  int unsigned idle_left = 0;

  id_to_type_table_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .msg_type_i      (msg_type_i),
    .key_id_i        (key_id_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .new_id_o        (new_id_o),
    .found_type_o    (found_type_o),
    .found_position_o(found_position_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one accepted command to the shadow table and queue its reply
  task automatic table_apply(input cmd_t c);
    reply_t r;
    int hit;
    int unsigned k;
    r.status = itt_pkg::ST_OK;
    r.new_id = '0;
    r.ftype  = '0;
    r.pos    = '0;
    hit = -1;
    if (c.action == ActUnused) return;
    // Search from the oldest entry, keep the first match
    if (c.action != itt_pkg::ACT_ADD) begin
      for (k = 0; k < fill; k++) begin
        if (hit < 0 && slots[k].id == c.key) hit = k;
      end
    end
    case (c.action)
      itt_pkg::ACT_ADD: begin
        if (fill >= itt_pkg::Capacity) begin
          r.status = itt_pkg::ST_FULL;
        end else begin
          r.new_id = id_next;
          slots[fill].id = id_next;
          slots[fill].mtype = c.mtype;
          fill++;
          id_next = (id_next == itt_pkg::MaxId) ? itt_pkg::InitialId : id_next + 1'b1;
        end
      end
      itt_pkg::ACT_LOOKUP: begin
        if (hit < 0) r.status = itt_pkg::ST_NOT_FOUND;
        else r.ftype = slots[hit].mtype;
      end
      default: begin
        if (hit < 0) begin
          r.status = itt_pkg::ST_NOT_FOUND;
        end else begin
          // Compact: shift later entries down one place
          for (k = hit + 1; k < fill; k++) slots[k-1] = slots[k];
          fill--;
          r.pos = itt_pkg::PosW'(hit);
        end
      end
    endcase
    expected_replies.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [30:0] want,
                             input logic [30:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Driver: present command beats from the pending queue with per-item gaps
  always @(posedge clk_i or negedge rst_ni) begin
    logic free;
    if (!rst_ni) begin
      start <= 1'b0;
      staged = 1'b0;
      idle_left = 0;
    end else begin
      free = !start || !busy;
      if (start && !busy) table_apply(cur);
      if (!staged && pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        staged = 1'b1;
        idle_left = nxt.gap;
      end
      if (free) begin
        if (staged && idle_left == 0) begin
          cur = nxt;
          staged = 1'b0;
          start <= 1'b1;
          action_i <= cur.action;
          msg_type_i <= cur.mtype;
          key_id_i <= cur.key;
        end else begin
          start <= 1'b0;
          if (staged) idle_left--;
        end
      end
    end
  end

  // Monitor: compare each result strobe with the oldest expected reply
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && done_o) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, status %0d new_id %0h", $time, status_o,
                 new_id_o);
        err_cnt++;
      end else begin
        want = expected_replies.pop_front();
        check_field("status", 31'(want.status), 31'(status_o));
        check_field("new_id", want.new_id, new_id_o);
        check_field("found_type", want.ftype, found_type_o);
        check_field("found_position", 31'(want.pos), 31'(found_position_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [itt_pkg::ActW-1:0] act,
                           input logic [itt_pkg::TypeW-1:0] mt,
                           input logic [itt_pkg::IdW-1:0] key, input int unsigned gap);
    cmd_t c;
    c.action = act;
    c.mtype = mt;
    c.key = key;
    c.gap = gap;
    pending_cmds.push_back(c);
  endtask

  // Favor live identifiers so lookups and removes mostly hit
  function automatic logic [itt_pkg::IdW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (fill > 0 && r < 75) return slots[$urandom_range(0, fill - 1)].id;
    if (r < 85) return id_next - itt_pkg::IdW'($urandom_range(1, 8));
    if (r < 88) return '0;
    if (r < 91) return itt_pkg::MaxId;
    return itt_pkg::IdW'($urandom);
  endfunction

  function automatic logic [itt_pkg::TypeW-1:0] pick_type();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return {itt_pkg::TypeW{1'b1}};
    return itt_pkg::TypeW'($urandom);
  endfunction

  initial begin
    int unsigned n;
    int unsigned j;
    int unsigned len;
    int unsigned mode;
    int unsigned r;
    logic burst;
    logic [itt_pkg::ActW-1:0] act;

    rst_ni = 1'b0;
    id_next = itt_pkg::InitialId;
    fill = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, edge values, removes with and without compaction
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::IdW'(1), 0);
    queue_cmd(itt_pkg::ACT_REMOVE, '0, '0, 1);
    queue_cmd(ActUnused, '0, '0, 0);
    queue_cmd(itt_pkg::ACT_ADD, '0, '0, 0);
    queue_cmd(itt_pkg::ACT_ADD, {itt_pkg::TypeW{1'b1}}, itt_pkg::MaxId, 2);
    queue_cmd(itt_pkg::ACT_ADD, itt_pkg::TypeW'($urandom), '0, 0);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::IdW'(1), 0);
    queue_cmd(itt_pkg::ACT_LOOKUP, {itt_pkg::TypeW{1'b1}}, itt_pkg::IdW'(2), 3);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, '0, 0);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::MaxId, 0);
    queue_cmd(itt_pkg::ACT_REMOVE, '0, itt_pkg::IdW'(2), 1);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::IdW'(3), 0);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::IdW'(2), 0);
    queue_cmd(itt_pkg::ACT_REMOVE, '0, itt_pkg::IdW'(3), 0);
    queue_cmd(itt_pkg::ACT_REMOVE, '0, itt_pkg::IdW'(1), 0);
    queue_cmd(itt_pkg::ACT_REMOVE, '0, itt_pkg::IdW'(1), 4);
    queue_cmd(ActUnused, {itt_pkg::TypeW{1'b1}}, itt_pkg::MaxId, 0);
    queue_cmd(itt_pkg::ACT_ADD, itt_pkg::TypeW'($urandom), '0, 0);
    queue_cmd(itt_pkg::ACT_LOOKUP, '0, itt_pkg::IdW'(4), 0);

    // Random: fill-heavy, drain-heavy and mixed phases
    n = 0;
    while (n < NumItems) begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(20, 60);
      burst = ($urandom_range(0, 3) == 0);
      for (j = 0; j < len && n < NumItems; j++) begin
        while (pending_cmds.size() >= 3) @(negedge clk_i);
        r = $urandom_range(0, 99);
        if (r < 3) act = ActUnused;
        else if (mode == 0) act = (r < 80) ? itt_pkg::ACT_ADD :
                                  (r < 92) ? itt_pkg::ACT_LOOKUP : itt_pkg::ACT_REMOVE;
        else if (mode == 1) act = (r < 25) ? itt_pkg::ACT_ADD :
                                  (r < 45) ? itt_pkg::ACT_LOOKUP : itt_pkg::ACT_REMOVE;
        else act = (r < 40) ? itt_pkg::ACT_ADD :
                   (r < 70) ? itt_pkg::ACT_LOOKUP : itt_pkg::ACT_REMOVE;
        queue_cmd(act, pick_type(), pick_key(), burst ? 0 : $urandom_range(0, 7));
        if (act != ActUnused) n++;
      end
    end

    // Drain: all beats accepted, all replies seen, then a quiet tail
    while (pending_cmds.size() > 0 || staged || start) @(negedge clk_i);
    while (expected_replies.size() > 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
